>>> hw/rtl/tpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpd_pkg: shared types and constants of the touch packet decoder
// Widths, event codes, register indexes, FSM types and the resolution
// alignment used when a sync packet is unpacked.
// ----------------------------------------------------------------------------
package tpd_pkg;

    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned XY_W           = 14;   // coordinate port width
    localparam int unsigned COORD_BITS_DEF = 14;   // default coordinate resolution
    localparam int unsigned KIND_W         = 3;
    localparam int unsigned BTN_W          = 2;
    localparam int unsigned CFG_ADDR_W     = 3;
    localparam int unsigned CFG_DATA_W     = 14;
    localparam int unsigned FIFO_DEPTH     = 2;    // packet queue between front and back
    localparam int unsigned PKT_BYTES      = 5;    // bytes kept per packet
    localparam int unsigned EV_NUM         = 5;    // number of event kinds

    // event kinds
    typedef logic [KIND_W-1:0] t_kind;
    localparam t_kind EV_PROX_IN  = 3'd0;
    localparam t_kind EV_MOTION   = 3'd1;
    localparam t_kind EV_PRESS    = 3'd2;
    localparam t_kind EV_RELEASE  = 3'd3;
    localparam t_kind EV_PROX_OUT = 3'd4;

    // configuration register indexes
    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;
    localparam t_cfg_addr REG_SWAP_AXES = 3'd0;
    localparam t_cfg_addr REG_MIRROR_X  = 3'd1;
    localparam t_cfg_addr REG_MIRROR_Y  = 3'd2;
    localparam t_cfg_addr REG_CAL_MIN_X = 3'd3;
    localparam t_cfg_addr REG_CAL_MAX_X = 3'd4;
    localparam t_cfg_addr REG_CAL_MIN_Y = 3'd5;
    localparam t_cfg_addr REG_CAL_MAX_Y = 3'd6;
    localparam t_cfg_addr REG_BUTTON_ID = 3'd7;

    // header bytes
    localparam logic [BYTE_W-1:0] MT_HEAD    = 8'h0a;
    localparam logic [BYTE_W-1:0] MT_TAG     = 8'h34;  // '4'
    localparam logic [BYTE_W-1:0] SYNC_FLAGS = 8'h60;  // pressure | player
    localparam int unsigned       SYNC_BIT   = 7;
    localparam logic [BYTE_W-1:0] LEN_SHORT  = 8'd5;
    localparam logic [BYTE_W-1:0] LEN_LONG   = 8'd6;

    // resolution select codes (byte 0 bits 2..1)
    typedef logic [1:0] t_res;
    localparam t_res RES_11 = 2'd0;
    localparam t_res RES_12 = 2'd1;
    localparam t_res RES_13 = 2'd2;
    localparam t_res RES_14 = 2'd3;

    typedef enum logic [1:0] {
        MODE_HEADER,
        MODE_BODY,
        MODE_SKIP
    } t_mode;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PREP,
        BK_DIV,
        BK_EMIT
    } t_back_state;

    typedef struct packed {
        logic                  swap_axes;
        logic                  mirror_x;
        logic                  mirror_y;
        logic [XY_W-1:0]       cal_min_x;
        logic [XY_W-1:0]       cal_max_x;
        logic [XY_W-1:0]       cal_min_y;
        logic [XY_W-1:0]       cal_max_y;
        logic [BTN_W-1:0]      button_id;
    } t_cfg;

    // mask the raw 14-bit axis to its resolution and left-align it to 14 bits
    function automatic logic [XY_W-1:0] res_align(input logic [XY_W-1:0] raw,
                                                  input t_res sel);
        logic [XY_W-1:0] v;
        case (sel)
            RES_11:  v = {raw[10:0], 3'b000};
            RES_12:  v = {raw[11:0], 2'b00};
            RES_13:  v = {raw[12:0], 1'b0};
            RES_14:  v = raw;
            default: v = raw;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/tpd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpd_front: byte framing
// Hunts for headers, skips multitouch packets, collects sync packets and
// pushes one decoded axis pair per finished sync packet into the queue.
// ----------------------------------------------------------------------------
module tpd_front import tpd_pkg::*; #(
    parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire  [BYTE_W-1:0]       i_rx_byte,
    input  wire                     i_space,
    output logic                    o_push,
    output logic [2*COORD_BITS:0]   o_rec
);

    localparam int unsigned IDX_W = $clog2(PKT_BYTES);

    t_mode              r_mode, n_mode;
    logic [IDX_W-1:0]   r_cnt, n_cnt;
    logic [BYTE_W-1:0]  r_len, n_len;
    logic [BYTE_W-1:0]  r_pkt [PKT_BYTES];

    logic               w_accept;
    logic [IDX_W-1:0]   w_cnt_hdr;
    logic [IDX_W-1:0]   w_cnt_inc;
    logic               w_is_mt;
    logic               w_is_sync;
    logic               w_body_end;
    logic [BYTE_W-1:0]  w_len_dec;
    logic               w_wr_en;
    logic [IDX_W-1:0]   w_wr_idx;
    logic [BYTE_W-1:0]  w_b4;
    logic [XY_W-1:0]    w_a1;
    logic [XY_W-1:0]    w_a2;

    assign o_ready  = i_space;
    assign w_accept = i_valid & i_space;

    // header and body bookkeeping
    assign w_cnt_hdr  = (r_cnt > IDX_W'(2)) ? '0 : r_cnt;
    assign w_cnt_inc  = r_cnt + IDX_W'(1);
    assign w_is_mt    = (r_pkt[0] == MT_HEAD) && (i_rx_byte == MT_TAG);
    assign w_is_sync  = r_pkt[0][SYNC_BIT] & ~r_pkt[1][SYNC_BIT] & ~i_rx_byte[SYNC_BIT];
    assign w_body_end = (BYTE_W'(w_cnt_inc) >= r_len);
    assign w_len_dec  = (r_len != '0) ? r_len - BYTE_W'(1) : '0;

    // next mode
    always_comb begin
        n_mode = r_mode;
        if (w_accept) begin
            case (r_mode)
                MODE_HEADER: begin
                    if (w_cnt_hdr == IDX_W'(2)) begin
                        if (w_is_mt) begin
                            if (r_pkt[1] > BYTE_W'(1)) begin
                                n_mode = MODE_SKIP;
                            end
                        end else if (w_is_sync) begin
                            n_mode = MODE_BODY;
                        end
                    end
                end
                MODE_BODY: begin
                    if (w_body_end) begin
                        n_mode = MODE_HEADER;
                    end
                end
                MODE_SKIP: begin
                    if (w_len_dec == '0) begin
                        n_mode = MODE_HEADER;
                    end
                end
                default: n_mode = MODE_HEADER;
            endcase
        end
    end

    // counters, byte store and push
    always_comb begin
        n_cnt    = r_cnt;
        n_len    = r_len;
        w_wr_en  = 1'b0;
        w_wr_idx = r_cnt;
        o_push   = 1'b0;
        if (w_accept) begin
            case (r_mode)
                MODE_HEADER: begin
                    w_wr_en  = 1'b1;
                    w_wr_idx = w_cnt_hdr;
                    if (w_cnt_hdr == IDX_W'(2)) begin
                        if (w_is_mt) begin
                            n_cnt = '0;
                            n_len = (r_pkt[1] > BYTE_W'(1)) ? r_pkt[1] - BYTE_W'(1) : '0;
                        end else if (w_is_sync) begin
                            n_cnt = IDX_W'(3);
                            n_len = ((r_pkt[0] & SYNC_FLAGS) != '0) ? LEN_LONG : LEN_SHORT;
                        end else begin
                            n_cnt = '0;
                        end
                    end else begin
                        n_cnt = w_cnt_hdr + IDX_W'(1);
                    end
                end
                MODE_BODY: begin
                    w_wr_en = (r_cnt < IDX_W'(PKT_BYTES));
                    n_cnt   = w_cnt_inc;
                    if (w_body_end) begin
                        n_cnt  = '0;
                        n_len  = '0;
                        o_push = 1'b1;
                    end
                end
                MODE_SKIP: begin
                    n_len = w_len_dec;
                    if (w_len_dec == '0) begin
                        n_cnt = '0;
                    end
                end
                default: begin
                    n_cnt = '0;
                    n_len = '0;
                end
            endcase
        end
    end

    // axis unpack; byte 4 may be the word arriving now
    assign w_b4  = (r_cnt == IDX_W'(4)) ? i_rx_byte : r_pkt[4];
    assign w_a1  = res_align({r_pkt[1][6:0], r_pkt[2][6:0]}, t_res'(r_pkt[0][2:1]));
    assign w_a2  = res_align({r_pkt[3][6:0], w_b4[6:0]}, t_res'(r_pkt[0][2:1]));
    assign o_rec = {r_pkt[0][0], w_a1[XY_W-1 -: COORD_BITS], w_a2[XY_W-1 -: COORD_BITS]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HEADER;
            r_cnt  <= '0;
            r_len  <= '0;
        end else begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_len  <= n_len;
        end
    end

    // packet bytes need no reset
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_pkt[w_wr_idx] <= i_rx_byte;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/tpd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpd_fifo: short packet queue
// Holds decoded axis pairs between framing and calibration.
// ----------------------------------------------------------------------------
module tpd_fifo import tpd_pkg::*; #(
    parameter int unsigned WIDTH = 29,
    parameter int unsigned DEPTH = FIFO_DEPTH
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_data,
    input  wire              i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/tpd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpd_back: calibration and event generation
// Pops one packet, calibrates x then y with a shared bit-serial divider,
// updates proximity and button state and emits the events in order.
// ----------------------------------------------------------------------------
module tpd_back import tpd_pkg::*; #(
    parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  t_cfg                    i_cfg,
    input  wire                     i_empty,
    input  wire  [2*COORD_BITS:0]   i_rec,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire                     i_ready,
    output logic [KIND_W-1:0]       o_event_kind,
    output logic [XY_W-1:0]         o_pos_x,
    output logic [XY_W-1:0]         o_pos_y,
    output logic [BTN_W-1:0]        o_button,
    output logic                    o_last_event
);

    localparam int unsigned CB    = COORD_BITS;
    localparam int unsigned CNT_W = $clog2(COORD_BITS);
    localparam logic [CB-1:0] FS  = '1;

    t_back_state        r_state, n_state;
    logic               r_axis;            // 0: x, 1: y
    logic [CB-1:0]      r_px, r_py;
    logic [CB-1:0]      r_res_x, r_res_y;
    logic [EV_NUM-1:0]  r_mask;
    logic               r_in_prox, r_held;
    logic [XY_W-1:0]    r_rem;
    logic [CB-1:0]      r_quo;
    logic [XY_W-1:0]    r_div;
    logic [CNT_W-1:0]   r_cnt;

    logic               r_ovalid;
    t_kind              r_okind;
    logic [CB-1:0]      r_ox, r_oy;
    logic [BTN_W-1:0]   r_obtn;
    logic               r_olast;

    // popped record fields
    logic               w_pressed;
    logic [CB-1:0]      w_d1, w_d2;

    // calibration setup
    logic [CB-1:0]      w_v, w_vv;
    logic [XY_W-1:0]    w_lo_raw, w_hi_raw, w_lo, w_hi;
    logic               w_inv_raw, w_flip, w_inv;
    logic [XY_W-1:0]    w_vv14, w_diff14, w_span;
    logic               w_zero, w_clamp;
    logic [CB-1:0]      w_diff;
    logic [2*CB-1:0]    w_num;

    // divider step
    logic [XY_W:0]      w_trial;
    logic               w_ge;
    logic [XY_W-1:0]    w_rem_next;
    logic [CB-1:0]      w_quo_next;
    logic               w_div_last;

    // emission
    logic               w_load;
    t_kind              w_kind;
    logic [EV_NUM-1:0]  w_pick, w_mask_after;
    logic               w_axis_done;
    logic [CB-1:0]      w_axis_res;

    assign {w_pressed, w_d1, w_d2} = i_rec;
    assign o_pop = (r_state == BK_IDLE) && !i_empty;

    // bound normalization, mirror and range checks for the current axis
    assign w_v       = r_axis ? r_py : r_px;
    assign w_lo_raw  = r_axis ? i_cfg.cal_min_y : i_cfg.cal_min_x;
    assign w_hi_raw  = r_axis ? i_cfg.cal_max_y : i_cfg.cal_max_x;
    assign w_inv_raw = r_axis ? i_cfg.mirror_y : i_cfg.mirror_x;
    assign w_flip    = (w_lo_raw > w_hi_raw);
    assign w_lo      = w_flip ? w_hi_raw : w_lo_raw;
    assign w_hi      = w_flip ? w_lo_raw : w_hi_raw;
    assign w_inv     = w_inv_raw | w_flip;
    assign w_vv      = w_inv ? ~w_v : w_v;           // FS - v
    assign w_vv14    = XY_W'(w_vv);
    assign w_zero    = (w_hi == w_lo) || (w_vv14 <= w_lo);
    assign w_diff14  = w_vv14 - w_lo;
    assign w_span    = w_hi - w_lo;
    assign w_clamp   = (w_diff14 > w_span);          // quotient would exceed FS
    assign w_diff    = w_diff14[CB-1:0];
    assign w_num     = {w_diff, {CB{1'b0}}} - {{CB{1'b0}}, w_diff};  // FS * diff

    // restoring divider, one quotient bit per cycle
    assign w_trial    = {r_rem, r_quo[CB-1]};
    assign w_ge       = (w_trial >= {1'b0, r_div});
    assign w_rem_next = w_ge ? XY_W'(w_trial - {1'b0, r_div}) : w_trial[XY_W-1:0];
    assign w_quo_next = {r_quo[CB-2:0], w_ge};
    assign w_div_last = (r_cnt == CNT_W'(COORD_BITS - 1));

    // axis result ready this cycle
    always_comb begin
        w_axis_done = 1'b0;
        w_axis_res  = w_quo_next;
        if (r_state == BK_PREP) begin
            if (w_zero) begin
                w_axis_done = 1'b1;
                w_axis_res  = '0;
            end else if (w_clamp) begin
                w_axis_done = 1'b1;
                w_axis_res  = FS;
            end
        end else if (r_state == BK_DIV) begin
            w_axis_done = w_div_last;
        end
    end

    // event pick: lowest pending kind first
    always_comb begin
        if (r_mask[EV_PROX_IN]) begin
            w_kind = EV_PROX_IN;
        end else if (r_mask[EV_MOTION]) begin
            w_kind = EV_MOTION;
        end else if (r_mask[EV_PRESS]) begin
            w_kind = EV_PRESS;
        end else if (r_mask[EV_RELEASE]) begin
            w_kind = EV_RELEASE;
        end else begin
            w_kind = EV_PROX_OUT;
        end
    end
    assign w_pick       = EV_NUM'(1) << w_kind;
    assign w_mask_after = r_mask & ~w_pick;
    assign w_load       = (r_state == BK_EMIT) && (!r_ovalid || i_ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    n_state = BK_PREP;
                end
            end
            BK_PREP: begin
                if (w_axis_done) begin
                    n_state = r_axis ? BK_EMIT : BK_PREP;
                end else begin
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (w_axis_done) begin
                    n_state = r_axis ? BK_EMIT : BK_PREP;
                end
            end
            BK_EMIT: begin
                if (w_load && (w_mask_after == '0)) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_axis    <= 1'b0;
            r_mask    <= '0;
            r_in_prox <= 1'b0;
            r_held    <= 1'b0;
            r_cnt     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_axis    <= 1'b0;
                // one pending bit per event kind, indexed by its code
                r_mask    <= {r_in_prox & ~w_pressed,     // proximity out
                              r_held & ~w_pressed,        // release
                              ~r_held & w_pressed,        // press
                              1'b1,                       // motion
                              ~r_in_prox & w_pressed};    // proximity in
                r_in_prox <= w_pressed;
                r_held    <= w_pressed;
            end
            if (w_axis_done) begin
                r_axis <= 1'b1;
            end
            if (r_state == BK_PREP) begin
                r_cnt <= '0;
            end else if (r_state == BK_DIV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (w_load) begin
                r_mask   <= w_mask_after;
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_px <= i_cfg.swap_axes ? w_d1 : w_d2;
            r_py <= i_cfg.swap_axes ? w_d2 : w_d1;
        end
        if (r_state == BK_PREP) begin
            r_rem <= XY_W'(w_num[2*CB-1:CB]);
            r_quo <= w_num[CB-1:0];
            r_div <= w_span;
        end else if (r_state == BK_DIV) begin
            r_rem <= w_rem_next;
            r_quo <= w_quo_next;
        end
        if (w_axis_done) begin
            if (r_axis) begin
                r_res_y <= w_axis_res;
            end else begin
                r_res_x <= w_axis_res;
            end
        end
        if (w_load) begin
            r_okind <= w_kind;
            r_ox    <= r_res_x;
            r_oy    <= r_res_y;
            r_obtn  <= ((w_kind == EV_PRESS) || (w_kind == EV_RELEASE)) ?
                       i_cfg.button_id : '0;
            r_olast <= (w_mask_after == '0);
        end
    end

    assign o_valid      = r_ovalid;
    assign o_event_kind = r_okind;
    assign o_pos_x      = XY_W'(r_ox);
    assign o_pos_y      = XY_W'(r_oy);
    assign o_button     = r_obtn;
    assign o_last_event = r_olast;

`ifndef SYNTH
    // emission only runs with events pending
    a_emit_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_EMIT) |-> (r_mask != '0))
        else $error("emit state with empty event mask");

    // idle leaves no stale events
    a_idle_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_IDLE) |-> (r_mask == '0))
        else $error("events pending while idle");

    // proximity in and out never come from one packet
    a_prox_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_mask[EV_PROX_IN] && r_mask[EV_PROX_OUT]))
        else $error("proximity in and out in one packet");

    // press and release never come from one packet
    a_btn_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_mask[EV_PRESS] && r_mask[EV_RELEASE]))
        else $error("press and release in one packet");

    // divider count stays within the coordinate width
    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIV) |-> (r_cnt <= CNT_W'(COORD_BITS - 1)))
        else $error("divider count overrun");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/touch_packet_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// touch_packet_decoder: serial touch controller packet decoder
// Frames controller bytes into packets, calibrates the coordinates and emits
// proximity, motion and button events.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   input   | i_valid / o_ready      | i_rx_byte
//   output  | o_valid / i_ready      | o_event_kind o_pos_x o_pos_y
//           |                        | o_button o_last_event
//   config  | i_cfg_we (no wait)     | i_cfg_addr i_cfg_wdata
//
// A byte is taken whenever the two-entry packet queue has room.
// Each sync packet is calibrated by the back end (a bit-serial divider
// shared by both axes) and then emitted as one output word per event,
// at most three events per packet.
// Reset is synchronous and active low; it clears framing, queue, event state
// and configuration. A stalled output holds its word in the output register;
// the front keeps taking bytes until the queue fills.
// ----------------------------------------------------------------------------
module touch_packet_decoder import tpd_pkg::*; #(
    parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire  [BYTE_W-1:0]     i_rx_byte,
    output logic                  o_valid,
    input  wire                   i_ready,
    output logic [KIND_W-1:0]     o_event_kind,
    output logic [XY_W-1:0]       o_pos_x,
    output logic [XY_W-1:0]       o_pos_y,
    output logic [BTN_W-1:0]      o_button,
    output logic                  o_last_event,
    input  wire                   i_cfg_we,
    input  wire  [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire  [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int unsigned REC_W = 2 * COORD_BITS + 1;

    t_cfg              r_cfg;
    logic              w_push, w_pop, w_full, w_empty;
    logic [REC_W-1:0]  w_rec_in, w_rec_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.swap_axes <= 1'b0;
            r_cfg.mirror_x  <= 1'b0;
            r_cfg.mirror_y  <= 1'b0;
            r_cfg.cal_min_x <= '0;
            r_cfg.cal_max_x <= '1;
            r_cfg.cal_min_y <= '0;
            r_cfg.cal_max_y <= '1;
            r_cfg.button_id <= BTN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SWAP_AXES: r_cfg.swap_axes <= i_cfg_wdata[0];
                REG_MIRROR_X:  r_cfg.mirror_x  <= i_cfg_wdata[0];
                REG_MIRROR_Y:  r_cfg.mirror_y  <= i_cfg_wdata[0];
                REG_CAL_MIN_X: r_cfg.cal_min_x <= i_cfg_wdata[XY_W-1:0];
                REG_CAL_MAX_X: r_cfg.cal_max_x <= i_cfg_wdata[XY_W-1:0];
                REG_CAL_MIN_Y: r_cfg.cal_min_y <= i_cfg_wdata[XY_W-1:0];
                REG_CAL_MAX_Y: r_cfg.cal_max_y <= i_cfg_wdata[XY_W-1:0];
                REG_BUTTON_ID: r_cfg.button_id <= i_cfg_wdata[BTN_W-1:0];
                default: ;
            endcase
        end
    end

    tpd_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .i_space   (~w_full),
        .o_push    (w_push),
        .o_rec     (w_rec_in)
    );

    tpd_fifo #(
        .WIDTH (REC_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_rec_in),
        .i_pop   (w_pop),
        .o_data  (w_rec_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    tpd_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_empty      (w_empty),
        .i_rec        (w_rec_out),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_event_kind (o_event_kind),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_button     (o_button),
        .o_last_event (o_last_event)
    );

endmodule
`default_nettype wire

>>> bench/touch_packet_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_packet_decoder_test: self-checking bench for the touch packet decoder
// Streams controller bytes (sync packets, multitouch skips, bad headers and
// noise) into the block and compares every event word it emits against an
// in-bench model of the framing, axis unpacking, calibration and the
// proximity and button event logic. Sender gaps and receiver stalls are random,
// with one long output hold-off that fills the packet queue.
// ----------------------------------------------------------------------------
module touch_packet_decoder_test;
    import tpd_pkg::*;

    localparam int unsigned COORD_W         = COORD_BITS_DEF;
    localparam int unsigned FULL_CODE       = (1 << COORD_W) - 1;
    // divider for both axes plus the event cycles, with margin
    localparam int unsigned BACK_END_CYCLES = 2 * (2 * (COORD_W + 1) + 1 + 3);
    localparam int unsigned RX_HOLD_CYCLES  = 400;

    typedef struct {
        t_kind             kind;
        logic [XY_W-1:0]   x;
        logic [XY_W-1:0]   y;
        logic [BTN_W-1:0]  btn;
        logic              last;
    } t_touch_event;

    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_style;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [BYTE_W-1:0]     i_rx_byte;
    logic                  o_valid;
    logic                  i_ready;
    logic [KIND_W-1:0]     o_event_kind;
    logic [XY_W-1:0]       o_pos_x;
    logic [XY_W-1:0]       o_pos_y;
    logic [BTN_W-1:0]      o_button;
    logic                  o_last_event;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    // model state
    t_cfg              cfg_shadow;
    logic [BYTE_W-1:0] rx_buf [PKT_BYTES];
    int unsigned       rx_count;
    int unsigned       want_len;
    t_mode             frame_mode;
    bit                prox_on;
    bit                btn_down;
    t_touch_event      touch_events [$];

    // bench bookkeeping
    int unsigned fail_count;
    int unsigned tx_burst_left;
    bit          tx_steady;
    bit          rx_hold;

    touch_packet_decoder u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_event_kind (o_event_kind),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_button     (o_button),
        .o_last_event (o_last_event),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------

    // 7+7-bit axis, masked to its resolution and left-aligned to 14 bits
    function automatic int unsigned axis_value(input logic [7:0] msb_byte,
                                               input logic [7:0] lsb_byte,
                                               input t_res sel);
        int unsigned raw;
        int unsigned bits;
        bits = 11 + sel;
        raw  = {msb_byte[6:0], lsb_byte[6:0]};
        raw  = (raw & ((1 << bits) - 1)) << (XY_W - bits);
        return (raw & ((1 << XY_W) - 1)) >> (XY_W - COORD_W);
    endfunction

    // linear map lo..hi onto 0..full scale; reversed bounds force a mirror
    function automatic int unsigned calibrate_axis(input int unsigned v,
                                                   input int unsigned lo,
                                                   input int unsigned hi,
                                                   input bit mirror);
        int unsigned t;
        int unsigned q;
        if (lo > hi) begin
            t      = lo;
            lo     = hi;
            hi     = t;
            mirror = 1'b1;
        end
        if (mirror) v = FULL_CODE - v;
        if (hi == lo || v <= lo) return 0;
        q = (FULL_CODE * (v - lo)) / (hi - lo);
        return (q > FULL_CODE) ? FULL_CODE : q;
    endfunction

    // complete sync packet: positions, then the event sequence
    function automatic void decode_touch();
        t_res         sel;
        bit           pressed;
        int unsigned  d1;
        int unsigned  d2;
        int unsigned  x;
        int unsigned  y;
        t_touch_event ev;
        t_touch_event batch [$];
        sel     = t_res'(rx_buf[0][2:1]);
        pressed = rx_buf[0][0];
        d1      = axis_value(rx_buf[1], rx_buf[2], sel);
        d2      = axis_value(rx_buf[3], rx_buf[4], sel);
        if (cfg_shadow.swap_axes) begin
            x = d1;
            y = d2;
        end else begin
            x = d2;
            y = d1;
        end
        x = calibrate_axis(x, cfg_shadow.cal_min_x, cfg_shadow.cal_max_x,
                           cfg_shadow.mirror_x);
        y = calibrate_axis(y, cfg_shadow.cal_min_y, cfg_shadow.cal_max_y,
                           cfg_shadow.mirror_y);
        ev.x    = x[XY_W-1:0];
        ev.y    = y[XY_W-1:0];
        ev.last = 1'b0;
        ev.btn  = '0;
        if (!prox_on && pressed) begin
            prox_on = 1'b1;
            ev.kind = EV_PROX_IN;
            batch.push_back(ev);
        end
        ev.kind = EV_MOTION;
        batch.push_back(ev);
        if (!btn_down && pressed) begin
            btn_down = 1'b1;
            ev.kind  = EV_PRESS;
            ev.btn   = cfg_shadow.button_id;
            batch.push_back(ev);
        end else if (btn_down && !pressed) begin
            btn_down = 1'b0;
            ev.kind  = EV_RELEASE;
            ev.btn   = cfg_shadow.button_id;
            batch.push_back(ev);
        end
        ev.btn = '0;
        if (prox_on && !pressed) begin
            prox_on = 1'b0;
            ev.kind = EV_PROX_OUT;
            batch.push_back(ev);
        end
        batch[batch.size()-1].last = 1'b1;
        foreach (batch[i]) touch_events.push_back(batch[i]);
    endfunction

    // framing of one accepted byte
    function automatic void frame_byte(input logic [BYTE_W-1:0] b);
        case (frame_mode)
            MODE_SKIP: begin
                if (want_len > 0) want_len--;
                if (want_len == 0) begin
                    frame_mode = MODE_HEADER;
                    rx_count   = 0;
                end
            end
            MODE_BODY: begin
                if (rx_count < PKT_BYTES) rx_buf[rx_count] = b;
                rx_count++;
                if (rx_count >= want_len) begin
                    frame_mode = MODE_HEADER;
                    rx_count   = 0;
                    want_len   = 0;
                    decode_touch();
                end
            end
            default: begin
                if (rx_count > 2) rx_count = 0;
                rx_buf[rx_count] = b;
                rx_count++;
                if (rx_count == 3) begin
                    if (rx_buf[0] == MT_HEAD && rx_buf[2] == MT_TAG) begin
                        rx_count = 0;
                        if (rx_buf[1] > 1) begin
                            want_len   = rx_buf[1] - 1;
                            frame_mode = MODE_SKIP;
                        end else begin
                            want_len = 0;
                        end
                    end else if (rx_buf[0][SYNC_BIT] && !rx_buf[1][SYNC_BIT]
                                 && !rx_buf[2][SYNC_BIT]) begin
                        want_len   = ((rx_buf[0] & SYNC_FLAGS) != 0) ? LEN_LONG : LEN_SHORT;
                        frame_mode = MODE_BODY;
                    end else begin
                        rx_count = 0;
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Output checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : event_check
        t_touch_event want;
        if (i_rst_n && o_valid && i_ready) begin
            if (touch_events.size() == 0) begin
                $error("unexpected event word: kind %0d x %0d y %0d",
                       o_event_kind, o_pos_x, o_pos_y);
                fail_count++;
            end else begin
                want = touch_events.pop_front();
                if (o_event_kind !== want.kind) begin
                    $error("event_kind: expected %0d, got %0d", want.kind, o_event_kind);
                    fail_count++;
                end
                if (o_pos_x !== want.x) begin
                    $error("pos_x: expected %0d, got %0d", want.x, o_pos_x);
                    fail_count++;
                end
                if (o_pos_y !== want.y) begin
                    $error("pos_y: expected %0d, got %0d", want.y, o_pos_y);
                    fail_count++;
                end
                if (o_button !== want.btn) begin
                    $error("button: expected %0d, got %0d", want.btn, o_button);
                    fail_count++;
                end
                if (o_last_event !== want.last) begin
                    $error("last_event: expected %0d, got %0d", want.last, o_last_event);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver pacing: random styles, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin : rx_pacing
        t_rx_style   style;
        int unsigned left;
        int unsigned tick;
        i_ready = 1'b0;
        style   = RX_FREE;
        left    = 0;
        tick    = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold) begin
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                rx_hold = 1'b0;
            end else begin
                if (left == 0) begin
                    style = t_rx_style'($urandom_range(0, 3));
                    left  = $urandom_range(20, 80);
                end
                left--;
                tick++;
                case (style)
                    RX_FREE:     i_ready <= 1'b1;
                    RX_COIN:     i_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   i_ready <= ($urandom_range(0, 3) == 0);
                    default:     i_ready <= ((tick % 7) < 4);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // one byte, in bursts with random gaps unless tx_steady is set
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        gap = 0;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 16);
            gap           = tx_steady ? 0 : $urandom_range(1, 6);
        end
        tx_burst_left--;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        frame_byte(b);
    endtask

    // stop offering and wait for every pending event, then for the back end
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid       <= 1'b0;
        tx_burst_left = 0;
        while (touch_events.size() != 0) @(posedge i_clk);
        repeat (BACK_END_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_addr addr, input int unsigned value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value[CFG_DATA_W-1:0];
        case (addr)
            REG_SWAP_AXES: cfg_shadow.swap_axes = value[0];
            REG_MIRROR_X:  cfg_shadow.mirror_x  = value[0];
            REG_MIRROR_Y:  cfg_shadow.mirror_y  = value[0];
            REG_CAL_MIN_X: cfg_shadow.cal_min_x = value[XY_W-1:0];
            REG_CAL_MAX_X: cfg_shadow.cal_max_x = value[XY_W-1:0];
            REG_CAL_MIN_Y: cfg_shadow.cal_min_y = value[XY_W-1:0];
            REG_CAL_MAX_Y: cfg_shadow.cal_max_y = value[XY_W-1:0];
            default:       cfg_shadow.button_id = value[BTN_W-1:0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input int unsigned swap, input int unsigned inv_x,
                                 input int unsigned inv_y, input int unsigned min_x,
                                 input int unsigned max_x, input int unsigned min_y,
                                 input int unsigned max_y, input int unsigned btn_id);
        wait_idle();
        cfg_write(REG_SWAP_AXES, swap);
        cfg_write(REG_MIRROR_X, inv_x);
        cfg_write(REG_MIRROR_Y, inv_y);
        cfg_write(REG_CAL_MIN_X, min_x);
        cfg_write(REG_CAL_MAX_X, max_x);
        cfg_write(REG_CAL_MIN_Y, min_y);
        cfg_write(REG_CAL_MAX_Y, max_y);
        cfg_write(REG_BUTTON_ID, btn_id);
    endtask

    task automatic random_setting();
        apply_setting($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                      $urandom_range(0, FULL_CODE), $urandom_range(0, FULL_CODE),
                      $urandom_range(0, FULL_CODE), $urandom_range(0, FULL_CODE),
                      $urandom_range(0, 3));
    endtask

    // sync packet with random body; 6 bytes when a flag bit is set
    task automatic send_touch(input logic [BYTE_W-1:0] head);
        send_byte(head);
        send_byte(BYTE_W'($urandom_range(0, 127)));
        send_byte(BYTE_W'($urandom_range(0, 127)));
        send_byte(BYTE_W'($urandom_range(0, 255)));
        send_byte(BYTE_W'($urandom_range(0, 255)));
        if ((head & SYNC_FLAGS) != 0) send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic send_multitouch(input logic [BYTE_W-1:0] len);
        send_byte(MT_HEAD);
        send_byte(len);
        send_byte(MT_TAG);
        for (int i = 1; i < len; i++) send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    function automatic logic [BYTE_W-1:0] random_head();
        return 8'h80 | BYTE_W'($urandom_range(0, 127));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // header classes and field extremes at reset configuration
    task automatic test_header_cases();
        // pressed, 14-bit, all-ones axes, bit 7 set in unchecked body bytes
        send_byte(8'h87);
        send_byte(8'h7f);
        send_byte(8'h7f);
        send_byte(8'hff);
        send_byte(8'hff);
        // pressure flag, 11-bit, released: motion, release, proximity out
        send_byte(8'hc0);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'haa);
        // multitouch packet skipped over its length
        send_byte(MT_HEAD);
        send_byte(8'h03);
        send_byte(MT_TAG);
        send_byte(8'h80);
        send_byte(8'hff);
        // multitouch with zero length skips nothing
        send_multitouch(8'h00);
        // bad header: bit 7 set in the second byte
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h00);
    endtask

    // calibration settings, extremes included, each with a few packets
    task automatic test_calibration_settings();
        for (int s = 0; s < 5; s++) begin
            case (s)
                0: apply_setting(1, 1, 0, 0, FULL_CODE, FULL_CODE, 0, 0);
                1: apply_setting(0, 0, 1, 8000, 8000, 100, 15000, 3);
                2: apply_setting(1, 1, 1, FULL_CODE, 0, 0, 1, 2);
                3: random_setting();
                default: apply_setting(0, 0, 0, 0, FULL_CODE, 0, FULL_CODE, 1);
            endcase
            repeat (2) send_touch(random_head());
        end
    endtask

    // receiver holds off while the sender keeps going, filling the queue
    task automatic test_output_stall();
        wait_idle();
        tx_steady = 1'b1;
        rx_hold   = 1'b1;
        repeat (5) send_touch(random_head());
        tx_steady = 1'b0;
        wait_idle();
    endtask

    // mostly well-formed packets, plus multitouch, noise and broken headers
    task automatic test_random_traffic();
        int unsigned       sent;
        int unsigned       pick;
        logic [BYTE_W-1:0] mt_len;
        for (int half = 0; half < 2; half++) begin
            random_setting();
            tx_steady = (half == 1);
            sent      = 0;
            while (sent < 14) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    send_touch(random_head());
                    sent += 5;
                end else if (pick < 80) begin
                    if ($urandom_range(0, 9) == 0)
                        mt_len = BYTE_W'($urandom_range(7, 20));
                    else
                        mt_len = BYTE_W'($urandom_range(0, 6));
                    send_multitouch(mt_len);
                    sent += (mt_len > 1) ? mt_len + 2 : 3;
                end else if (pick < 90) begin
                    send_byte(BYTE_W'($urandom_range(0, 255)));
                    sent += 1;
                end else begin
                    // broken headers: sync with a flagged second byte, or
                    // a multitouch start without its tag
                    if ($urandom_range(0, 1)) begin
                        send_byte(random_head());
                        send_byte(8'h80 | BYTE_W'($urandom_range(0, 127)));
                        send_byte(BYTE_W'($urandom_range(0, 255)));
                    end else begin
                        send_byte(MT_HEAD);
                        send_byte(BYTE_W'($urandom_range(0, 255)));
                        send_byte(MT_TAG ^ (8'h01 << $urandom_range(0, 7)));
                    end
                    sent += 3;
                end
            end
        end
        tx_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        int unsigned guard;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_rx_byte     = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        fail_count    = 0;
        tx_burst_left = 0;
        tx_steady     = 1'b0;
        rx_hold       = 1'b0;
        cfg_shadow.swap_axes = 1'b0;
        cfg_shadow.mirror_x  = 1'b0;
        cfg_shadow.mirror_y  = 1'b0;
        cfg_shadow.cal_min_x = '0;
        cfg_shadow.cal_max_x = XY_W'(FULL_CODE);
        cfg_shadow.cal_min_y = '0;
        cfg_shadow.cal_max_y = XY_W'(FULL_CODE);
        cfg_shadow.button_id = 2'd1;
        foreach (rx_buf[i]) rx_buf[i] = '0;
        rx_count   = 0;
        want_len   = 0;
        frame_mode = MODE_HEADER;
        prox_on    = 1'b0;
        btn_down   = 1'b0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_header_cases();
        test_calibration_settings();
        test_output_stall();
        test_random_traffic();

        // drain with a bound, then let the back end settle
        @(negedge i_clk);
        i_valid <= 1'b0;
        guard = 0;
        while (touch_events.size() != 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (BACK_END_CYCLES) @(posedge i_clk);
        if (touch_events.size() != 0) begin
            $error("%0d expected events never arrived", touch_events.size());
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/tpd_pkg.sv
hw/rtl/tpd_front.sv
hw/rtl/tpd_fifo.sv
hw/rtl/tpd_back.sv
hw/rtl/touch_packet_decoder.sv
bench/touch_packet_decoder_test.sv
